@@ hdl/assert_macros.svh @@
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

@@ hdl/sqns_pkg.sv @@
// ----------------------------------------------------------------------------
// sqns_pkg
// types and constants for the square / noise sound channel
// ----------------------------------------------------------------------------
package sqns_pkg;

    localparam int WaveletSteps = 16;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_NOTE  = 2'd1,
        CMD_NOISE = 2'd2,
        CMD_QUIET = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        REG_VOL_LOW   = 3'd0,
        REG_VOL_HIGH  = 3'd1,
        REG_VOL_MODE  = 3'd2,
        REG_VOL_SPEED = 3'd3,
        REG_PER_LOW   = 3'd4,
        REG_PER_HIGH  = 3'd5,
        REG_PER_MODE  = 3'd6,
        REG_PER_SPEED = 3'd7
    } t_reg_idx;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    localparam logic [1:0] EDGE_LOOP    = 2'd0;
    localparam logic [1:0] EDGE_REVERSE = 2'd1;
    localparam logic [1:0] EDGE_SILENCE = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] note_length;
        logic [14:0] noise_seed;
        logic        noise_tap_select;
        logic [7:0]  noise_period;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               tone_silent;
    } t_out_beat;

    typedef struct packed {
        logic [3:0]  vol_low;
        logic [3:0]  vol_high;
        logic [3:0]  vol_mode;
        logic [7:0]  vol_speed;
        logic [14:0] per_low;
        logic [14:0] per_high;
        logic [3:0]  per_mode;
        logic [7:0]  per_speed;
    } t_cfg;

    // magnitude table, rows 0..16, positions 0..7 (mirrored)
    function automatic logic [11:0] wavelet_mag(input logic [4:0] row, input logic [3:0] p);
        logic [11:0] m;
        begin
            m = 12'd0;
            case ({row, p[2:0]})
                8'h08: m = 6;    8'h09: m = 13;   8'h0A: m = 16;   8'h0B: m = 20;
                8'h0C: m = 26;   8'h0D: m = 36;   8'h0E: m = 60;   8'h0F: m = 256;
                8'h10: m = 13;   8'h11: m = 27;   8'h12: m = 32;   8'h13: m = 39;
                8'h14: m = 50;   8'h15: m = 71;   8'h16: m = 120;  8'h17: m = 512;
                8'h18: m = 19;   8'h19: m = 40;   8'h1A: m = 48;   8'h1B: m = 59;
                8'h1C: m = 76;   8'h1D: m = 107;  8'h1E: m = 180;  8'h1F: m = 768;
                8'h20: m = 26;   8'h21: m = 55;   8'h22: m = 64;   8'h23: m = 78;
                8'h24: m = 101;  8'h25: m = 142;  8'h26: m = 240;  8'h27: m = 1024;
                8'h28: m = 32;   8'h29: m = 68;   8'h2A: m = 80;   8'h2B: m = 98;
                8'h2C: m = 127;  8'h2D: m = 178;  8'h2E: m = 300;  8'h2F: m = 1280;
                8'h30: m = 38;   8'h31: m = 81;   8'h32: m = 96;   8'h33: m = 117;
                8'h34: m = 151;  8'h35: m = 213;  8'h36: m = 360;  8'h37: m = 1536;
                8'h38: m = 45;   8'h39: m = 95;   8'h3A: m = 112;  8'h3B: m = 137;
                8'h3C: m = 177;  8'h3D: m = 249;  8'h3E: m = 420;  8'h3F: m = 1792;
                8'h40: m = 51;   8'h41: m = 108;  8'h42: m = 128;  8'h43: m = 157;
                8'h44: m = 202;  8'h45: m = 284;  8'h46: m = 480;  8'h47: m = 2048;
                8'h48: m = 58;   8'h49: m = 122;  8'h4A: m = 144;  8'h4B: m = 177;
                8'h4C: m = 228;  8'h4D: m = 320;  8'h4E: m = 540;  8'h4F: m = 2304;
                8'h50: m = 64;   8'h51: m = 136;  8'h52: m = 161;  8'h53: m = 196;
                8'h54: m = 252;  8'h55: m = 355;  8'h56: m = 600;  8'h57: m = 2560;
                8'h58: m = 70;   8'h59: m = 149;  8'h5A: m = 177;  8'h5B: m = 216;
                8'h5C: m = 278;  8'h5D: m = 391;  8'h5E: m = 660;  8'h5F: m = 2816;
                8'h60: m = 77;   8'h61: m = 163;  8'h62: m = 192;  8'h63: m = 235;
                8'h64: m = 303;  8'h65: m = 426;  8'h66: m = 720;  8'h67: m = 3072;
                8'h68: m = 83;   8'h69: m = 176;  8'h6A: m = 208;  8'h6B: m = 255;
                8'h6C: m = 329;  8'h6D: m = 462;  8'h6E: m = 780;  8'h6F: m = 3328;
                8'h70: m = 90;   8'h71: m = 190;  8'h72: m = 224;  8'h73: m = 274;
                8'h74: m = 353;  8'h75: m = 496;  8'h76: m = 839;  8'h77: m = 3584;
                8'h78: m = 96;   8'h79: m = 203;  8'h7A: m = 240;  8'h7B: m = 294;
                8'h7C: m = 379;  8'h7D: m = 532;  8'h7E: m = 899;  8'h7F: m = 3840;
                8'h80: m = 102;  8'h81: m = 217;  8'h82: m = 257;  8'h83: m = 314;
                8'h84: m = 404;  8'h85: m = 567;  8'h86: m = 958;  8'h87: m = 4095;
                default: m = 12'd0;
            endcase
            wavelet_mag = m;
        end
    endfunction

    // step wavelet for one row and position; row 16 is the saturated one
    function automatic logic [15:0] wavelet(input logic [4:0] row, input logic [3:0] pos);
        logic [3:0]  p;
        logic [15:0] v;
        begin
            p = pos[3] ? 4'(15 - pos) : pos;
            v = 16'(wavelet_mag(row, p));
            // odd positions of the first half are negative
            if (p[0]) v = 16'd0 - v;
            wavelet = v;
        end
    endfunction

endpackage

@@ hdl/sqns_core.sv @@
// ----------------------------------------------------------------------------
// sqns_core
// per-beat state update of the voice: sweeps, wavelet, noise shifter
// ----------------------------------------------------------------------------
module sqns_core
    import sqns_pkg::*;
#(
    parameter int LengthUnit = 100
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_go,
    input  t_in_beat  i_beat,
    output t_out_beat o_res,
    output logic      o_has_res
);

    `include "assert_macros.svh"

    // length counter wide enough for the longest note
    localparam int LenW = $clog2(65535 * LengthUnit + 1);

    logic [15:0] r_wave, n_wave;
    logic [4:0]  r_tgt, n_tgt, r_prev, n_prev;
    logic [4:0]  r_wpos, n_wpos;
    logic [LenW-1:0] r_len, n_len;
    logic        r_unl, n_unl;
    logic [15:0] r_cd, n_cd;
    logic [14:0] r_hp, n_hp;
    logic [3:0]  r_lvl, n_lvl;
    logic [3:0]  r_bvl, n_bvl, r_bvh, n_bvh;
    logic [14:0] r_bpl, n_bpl, r_bph, n_bph;
    logic [1:0]  r_vdir, n_vdir, r_pdir, n_pdir;
    logic [8:0]  r_vcnt, n_vcnt;
    logic [7:0]  r_pcnt, n_pcnt;
    logic        r_up, n_up;
    logic [14:0] r_nz, n_nz;
    logic        r_tap, n_tap;
    logic [7:0]  r_rel, n_rel;

    // next state and result for one beat
    always_comb begin
        logic [4:0]  lv5, d5;
        logic        pos, mag_big;
        logic [4:0]  row;
        logic [5:0]  diff;
        logic [15:0] dlt, smp;
        logic [8:0]  vc;
        logic [7:0]  pc;
        logic        a, expired;
        logic [15:0] r;
        n_wave = r_wave; n_tgt = r_tgt; n_prev = r_prev; n_wpos = r_wpos;
        n_len = r_len; n_unl = r_unl; n_cd = r_cd; n_hp = r_hp; n_lvl = r_lvl;
        n_bvl = r_bvl; n_bvh = r_bvh; n_bpl = r_bpl; n_bph = r_bph;
        n_vdir = r_vdir; n_pdir = r_pdir; n_vcnt = r_vcnt; n_pcnt = r_pcnt;
        n_up = r_up; n_nz = r_nz; n_tap = r_tap; n_rel = r_rel;
        o_has_res = 1'b0;
        smp = 16'd0;
        lv5 = 5'd0; d5 = 5'd0; pos = 1'b0; mag_big = 1'b0; row = 5'd0; diff = 6'd0;
        dlt = 16'd0; vc = 9'd0; pc = 8'd0; a = 1'b0; expired = 1'b0; r = 16'd0;
        case (t_cmd'(i_beat.command))
            CMD_NOTE: begin
                n_bvl = i_cfg.vol_low; n_bvh = i_cfg.vol_high;
                n_bpl = i_cfg.per_low; n_bph = i_cfg.per_high;
                n_vdir = i_cfg.vol_mode[3:2]; n_pdir = i_cfg.per_mode[3:2];
                n_unl = (i_beat.note_length == 16'd0);
                n_len = LenW'(i_beat.note_length * LenW'(LengthUnit));
                n_vcnt = 9'd0; n_pcnt = 8'd0;
                n_hp = (i_cfg.per_mode[3:2] == DIR_DOWN) ? i_cfg.per_high : i_cfg.per_low;
                n_lvl = (i_cfg.vol_mode[3:2] == DIR_DOWN) ? i_cfg.vol_high : i_cfg.vol_low;
                n_nz = 15'd0; n_tap = 1'b0;
            end
            CMD_NOISE: begin
                n_nz = i_beat.noise_seed; n_tap = i_beat.noise_tap_select;
                n_unl = (i_beat.note_length == 16'd0);
                n_len = LenW'(i_beat.note_length);
                n_rel = i_beat.noise_period; n_cd = 16'(i_beat.noise_period);
                n_wave = 16'd0; n_tgt = 5'd0; n_prev = 5'd0; n_wpos = 5'(WaveletSteps);
            end
            CMD_QUIET: begin
                n_unl = 1'b1; n_len = '0; n_lvl = 4'd0; n_nz = 15'd0; n_tap = 1'b0;
            end
            default: begin
                o_has_res = 1'b1;
                if (r_nz == 15'd0) begin
                    if (!r_unl) begin
                        if (r_len == '0) n_lvl = 4'd0;
                        else n_len = r_len - LenW'(1);
                    end
                    if (r_cd != 16'd0) begin
                        n_cd = r_cd - 16'd1;
                    end else if (n_lvl == 4'd0) begin
                        if (r_wave != 16'd0) begin
                            n_prev = r_tgt; n_tgt = 5'd0;
                            n_wpos = (r_tgt == 5'd0) ? 5'(WaveletSteps) : 5'd0;
                            n_cd = 16'd16;
                        end
                    end else begin
                        lv5 = r_up ? {1'b0, n_lvl} : 5'(-{1'b0, n_lvl});
                        n_prev = r_tgt; n_tgt = lv5;
                        n_wpos = (lv5 == r_tgt) ? 5'(WaveletSteps) : 5'd0;
                        n_cd = 16'(r_hp);
                        n_up = !r_up;
                        // volume sweep
                        if (r_vdir != DIR_NONE) begin
                            vc = r_vcnt + 9'd1;
                            n_vcnt = vc;
                            if (vc > 9'(i_cfg.vol_speed)) begin
                                n_vcnt = 9'd0;
                                if (r_vdir == DIR_UP && n_lvl < r_bvh) begin
                                    n_lvl = n_lvl + 4'd1;
                                end else if (r_vdir != DIR_UP && n_lvl > r_bvl) begin
                                    n_lvl = n_lvl - 4'd1;
                                end else begin
                                    case (i_cfg.vol_mode[1:0])
                                        EDGE_LOOP: n_lvl = (r_vdir == DIR_UP) ? r_bvl : r_bvh;
                                        EDGE_REVERSE: begin
                                            if (r_vdir == DIR_UP) begin
                                                n_vdir = DIR_DOWN; n_lvl = n_lvl - 4'd1;
                                            end else begin
                                                n_vdir = DIR_UP; n_lvl = n_lvl + 4'd1;
                                            end
                                        end
                                        EDGE_SILENCE: begin
                                            n_lvl = 4'd0; n_vdir = DIR_NONE;
                                        end
                                        default: begin
                                            n_bvl = n_lvl; n_bvh = n_lvl; n_vdir = DIR_NONE;
                                        end
                                    endcase
                                end
                            end
                        end
                        // period sweep
                        if (r_pdir != DIR_NONE) begin
                            pc = r_pcnt + 8'd1;
                            n_pcnt = pc;
                            if (pc >= i_cfg.per_speed) begin
                                n_pcnt = 8'd0;
                                if (r_pdir == DIR_UP && r_hp < r_bph) begin
                                    n_hp = r_hp + 15'd1;
                                end else if (r_pdir != DIR_UP && r_hp > r_bpl) begin
                                    n_hp = r_hp - 15'd1;
                                end else begin
                                    case (i_cfg.per_mode[1:0])
                                        EDGE_LOOP: n_hp = (r_pdir == DIR_UP) ? r_bpl : r_bph;
                                        EDGE_REVERSE: begin
                                            if (r_pdir == DIR_UP) begin
                                                n_pdir = DIR_DOWN; n_hp = r_hp - 15'd1;
                                            end else begin
                                                n_pdir = DIR_UP; n_hp = r_hp + 15'd1;
                                            end
                                        end
                                        EDGE_SILENCE: begin
                                            n_lvl = 4'd0; n_pdir = DIR_NONE;
                                        end
                                        default: begin
                                            n_bpl = r_hp; n_bph = r_hp; n_pdir = DIR_NONE;
                                        end
                                    endcase
                                end
                            end
                        end
                    end
                    // wavelet accumulate
                    if (n_wpos < 5'(WaveletSteps)) begin
                        diff = {n_prev[4], n_prev} - {n_tgt[4], n_tgt};
                        pos = !diff[5] && (diff != 6'd0);
                        d5 = diff[5] ? 5'(-diff) : diff[4:0];
                        mag_big = (diff[5] ? (6'(-diff) > 6'd16) : (diff > 6'd16));
                        row = mag_big ? 5'd16 : d5;
                        dlt = wavelet(row, n_wpos[3:0]);
                        n_wave = pos ? r_wave + dlt : r_wave - dlt;
                        n_wpos = n_wpos + 5'd1;
                    end
                    smp = n_wave;
                end else begin
                    if (!r_unl) begin
                        if (r_len == '0) expired = 1'b1;
                        else n_len = r_len - LenW'(1);
                    end
                    if (expired) begin
                        n_nz = 15'd0; n_tap = 1'b0; smp = 16'd0;
                    end else begin
                        if (r_cd != 16'd0) begin
                            n_cd = r_cd - 16'd1;
                        end else begin
                            a = r_tap ? r_nz[6] : r_nz[1];
                            r = {(a != r_nz[0]), r_nz};
                            n_cd = 16'(r_rel);
                            n_nz = r[15:1];
                        end
                        smp = 16'(n_nz[14:3]) - 16'd2048;
                    end
                end
            end
        endcase
        o_res.sample = smp;
        o_res.tone_silent = (n_wave == 16'd0);
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave <= 16'd0; r_tgt <= 5'd0; r_prev <= 5'd0; r_wpos <= 5'(WaveletSteps);
            r_len <= '0; r_unl <= 1'b1; r_cd <= 16'd0; r_hp <= 15'd16; r_lvl <= 4'd0;
            r_bvl <= 4'd1; r_bvh <= 4'd1; r_bpl <= 15'd16; r_bph <= 15'd16;
            r_vdir <= DIR_NONE; r_pdir <= DIR_NONE; r_vcnt <= 9'd0; r_pcnt <= 8'd0;
            r_up <= 1'b0; r_nz <= 15'd0; r_tap <= 1'b0; r_rel <= 8'd0;
        end else if (i_go) begin
            r_wave <= n_wave; r_tgt <= n_tgt; r_prev <= n_prev; r_wpos <= n_wpos;
            r_len <= n_len; r_unl <= n_unl; r_cd <= n_cd; r_hp <= n_hp; r_lvl <= n_lvl;
            r_bvl <= n_bvl; r_bvh <= n_bvh; r_bpl <= n_bpl; r_bph <= n_bph;
            r_vdir <= n_vdir; r_pdir <= n_pdir; r_vcnt <= n_vcnt; r_pcnt <= n_pcnt;
            r_up <= n_up; r_nz <= n_nz; r_tap <= n_tap; r_rel <= n_rel;
        end
    end

    `ASSERT_CLK(a_wpos_range, i_clk, i_rst_n, r_wpos <= 5'(WaveletSteps), "wavelet index out of range")
    `ASSERT_NEXT(a_noise_halts_wave, i_clk, i_rst_n, i_go && i_beat.command == CMD_NOISE, r_wave == 16'd0 && r_wpos == 5'(WaveletSteps), "noise start did not halt wavelet")
    `ASSERT_NEXT(a_quiet_tone, i_clk, i_rst_n, i_go && i_beat.command == CMD_QUIET, r_nz == 15'd0 && r_lvl == 4'd0 && r_unl, "silence command did not clear voice")

endmodule

@@ hdl/square_noise_sound_channel_top.sv @@
// ----------------------------------------------------------------------------
// square_noise_sound_channel_top
// square wave and noise sound voice with a valid / stall beat interface
// ----------------------------------------------------------------------------
// Usage: configuration registers are written through i_cfg_we / i_cfg_idx /
// i_cfg_data while the voice is idle. Command beats enter on the input
// channel (i_in_valid, o_in_stall); a tick beat yields one sample beat on
// the output channel (o_out_valid, i_out_stall), other commands yield none.
// A tick's sample enters the output register at the edge that accepts it.
// Throughput: one beat per cycle unless stalled; the whole state update is
// one pass of logic between the state registers and the output register.
// The input stalls only while a sample waits in the output register and the
// receiver stalls it; a stalled sample holds its value.
// Reset: synchronous, active low; registers take their reset values, the
// voice is in tone mode, silent, and the output register is empty.
// ----------------------------------------------------------------------------
module square_noise_sound_channel_top
    import sqns_pkg::*;
#(
    parameter int LENGTH_UNIT = 100
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [14:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_beat    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_beat   o_out_data
);

    `include "assert_macros.svh"

    t_cfg      r_cfg;
    t_out_beat w_res;
    logic      w_has;
    logic      w_go;
    logic      r_ov;
    t_out_beat r_od;

    // input takes a beat unless a held result blocks the output
    assign o_in_stall = r_ov && i_out_stall;
    assign w_go = i_in_valid && !o_in_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{vol_low: 4'd1, vol_high: 4'd1, vol_mode: 4'd0, vol_speed: 8'd0,
                       per_low: 15'd16, per_high: 15'd16, per_mode: 4'd0, per_speed: 8'd0};
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_VOL_LOW:   r_cfg.vol_low <= i_cfg_data[3:0];
                REG_VOL_HIGH:  r_cfg.vol_high <= i_cfg_data[3:0];
                REG_VOL_MODE:  r_cfg.vol_mode <= i_cfg_data[3:0];
                REG_VOL_SPEED: r_cfg.vol_speed <= i_cfg_data[7:0];
                REG_PER_LOW:   r_cfg.per_low <= i_cfg_data;
                REG_PER_HIGH:  r_cfg.per_high <= i_cfg_data;
                REG_PER_MODE:  r_cfg.per_mode <= i_cfg_data[3:0];
                default:       r_cfg.per_speed <= i_cfg_data[7:0];
            endcase
        end
    end

    sqns_core #(.LengthUnit(LENGTH_UNIT)) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_go     (w_go),
        .i_beat   (i_in_data),
        .o_res    (w_res),
        .o_has_res(w_has)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (!(r_ov && i_out_stall)) begin
            r_ov <= w_go && w_has;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_has) begin
            r_od <= w_res;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;

    `ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_ov && i_out_stall, r_ov && $stable(r_od), "stalled beat changed")
    `ASSERT_NEXT(a_tick_gives_beat, i_clk, i_rst_n, w_go && i_in_data.command == CMD_TICK, r_ov, "tick produced no beat")
    `ASSERT_NEXT(a_cmd_no_beat, i_clk, i_rst_n, !(r_ov && i_out_stall) && !(w_go && i_in_data.command == CMD_TICK), !r_ov, "beat without tick")

endmodule

@@ dv/square_noise_sound_channel_checker.sv @@
// ----------------------------------------------------------------------------
// square_noise_sound_channel_checker
// watches the config port and both beat channels, keeps its own copy of the
// voice state, predicts the sample of every tick beat and compares it with
// the sample beat that comes out
// ----------------------------------------------------------------------------
module square_noise_sound_channel_checker
    import sqns_pkg::*;
#(
    parameter int LENGTH_UNIT = 100
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [14:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_beat    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_beat   i_out_data,
    output int          o_fail_count,
    output int          o_pending
);

    // step wavelet magnitudes, first half of each row; the second half mirrors
    int step_mag [17][8] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0},
        '{6, 13, 16, 20, 26, 36, 60, 256},
        '{13, 27, 32, 39, 50, 71, 120, 512},
        '{19, 40, 48, 59, 76, 107, 180, 768},
        '{26, 55, 64, 78, 101, 142, 240, 1024},
        '{32, 68, 80, 98, 127, 178, 300, 1280},
        '{38, 81, 96, 117, 151, 213, 360, 1536},
        '{45, 95, 112, 137, 177, 249, 420, 1792},
        '{51, 108, 128, 157, 202, 284, 480, 2048},
        '{58, 122, 144, 177, 228, 320, 540, 2304},
        '{64, 136, 161, 196, 252, 355, 600, 2560},
        '{70, 149, 177, 216, 278, 391, 660, 2816},
        '{77, 163, 192, 235, 303, 426, 720, 3072},
        '{83, 176, 208, 255, 329, 462, 780, 3328},
        '{90, 190, 224, 274, 353, 496, 839, 3584},
        '{96, 203, 240, 294, 379, 532, 899, 3840},
        '{102, 217, 257, 314, 404, 567, 958, 4095}
    };

    // live register copy
    t_cfg        cfg;

    // voice state copy
    logic [15:0] wave_out;
    int          wave_tgt;
    int          wave_prev;
    int          wave_pos;
    int unsigned len_left;
    logic        len_free;
    logic [15:0] countdown;
    logic [14:0] half_per;
    logic [3:0]  level;
    logic [3:0]  bnd_vlow;
    logic [3:0]  bnd_vhigh;
    logic [14:0] bnd_plow;
    logic [14:0] bnd_phigh;
    logic [1:0]  vdir;
    logic [1:0]  pdir;
    int          vol_count;
    int          per_count;
    logic        upper;
    logic [14:0] lfsr;
    logic        lfsr_tap;
    logic [7:0]  lfsr_reload;

    t_out_beat   samples_due [$];

    function automatic logic [15:0] step_value(int row, int pos);
        int p;
        int v;
        p = (pos > 7) ? 15 - pos : pos;
        v = step_mag[row][p];
        if (p % 2 == 1) v = -v;
        return v[15:0];
    endfunction

    task automatic wave_silence();
        wave_out = '0;
        wave_tgt = 0;
        wave_prev = 0;
        wave_pos = WaveletSteps;
    endtask

    task automatic retarget(int lvl);
        wave_prev = wave_tgt;
        wave_tgt = lvl;
        wave_pos = (wave_tgt == wave_prev) ? WaveletSteps : 0;
    endtask

    task automatic wave_advance();
        int d;
        int mag;
        logic [15:0] delta;
        if (wave_pos < WaveletSteps) begin
            d = wave_prev - wave_tgt;
            mag = (d < 0) ? -d : d;
            if (mag > 16) mag = 16;
            delta = step_value(mag, wave_pos);
            if (d > 0) wave_out = wave_out + delta;
            else wave_out = wave_out - delta;
            wave_pos++;
        end
    endtask

    task automatic volume_step();
        logic [1:0] edge_kind;
        edge_kind = cfg.vol_mode[1:0];
        if (vdir == DIR_NONE) return;
        vol_count++;
        if (vol_count <= int'(cfg.vol_speed)) return;
        vol_count = 0;
        if (vdir == DIR_UP) begin
            if (level < bnd_vhigh) begin
                level = level + 4'd1;
                return;
            end
        end else if (level > bnd_vlow) begin
            level = level - 4'd1;
            return;
        end
        case (edge_kind)
            EDGE_LOOP: level = (vdir == DIR_UP) ? bnd_vlow : bnd_vhigh;
            EDGE_REVERSE: begin
                if (vdir == DIR_UP) begin
                    vdir = DIR_DOWN;
                    level = level - 4'd1;
                end else begin
                    vdir = DIR_UP;
                    level = level + 4'd1;
                end
            end
            EDGE_SILENCE: begin
                level = '0;
                vdir = DIR_NONE;
            end
            default: begin
                bnd_vlow = level;
                bnd_vhigh = level;
                vdir = DIR_NONE;
            end
        endcase
    endtask

    task automatic period_step();
        logic [1:0] edge_kind;
        edge_kind = cfg.per_mode[1:0];
        if (pdir == DIR_NONE) return;
        per_count++;
        if (per_count < int'(cfg.per_speed)) return;
        per_count = 0;
        if (pdir == DIR_UP) begin
            if (half_per < bnd_phigh) begin
                half_per = half_per + 15'd1;
                return;
            end
        end else if (half_per > bnd_plow) begin
            half_per = half_per - 15'd1;
            return;
        end
        case (edge_kind)
            EDGE_LOOP: half_per = (pdir == DIR_UP) ? bnd_plow : bnd_phigh;
            EDGE_REVERSE: begin
                if (pdir == DIR_UP) begin
                    pdir = DIR_DOWN;
                    half_per = half_per - 15'd1;
                end else begin
                    pdir = DIR_UP;
                    half_per = half_per + 15'd1;
                end
            end
            EDGE_SILENCE: begin
                level = '0;
                pdir = DIR_NONE;
            end
            default: begin
                bnd_plow = half_per;
                bnd_phigh = half_per;
                pdir = DIR_NONE;
            end
        endcase
    endtask

    task automatic voice_reset();
        cfg = '{vol_low: 4'd1, vol_high: 4'd1, vol_mode: 4'd0, vol_speed: 8'd0,
                per_low: 15'd16, per_high: 15'd16, per_mode: 4'd0, per_speed: 8'd0};
        wave_silence();
        len_left = 0;
        len_free = 1'b1;
        countdown = '0;
        half_per = 15'd16;
        level = '0;
        bnd_vlow = cfg.vol_low;
        bnd_vhigh = cfg.vol_high;
        bnd_plow = cfg.per_low;
        bnd_phigh = cfg.per_high;
        vdir = DIR_NONE;
        pdir = DIR_NONE;
        vol_count = 0;
        per_count = 0;
        upper = 1'b0;
        lfsr = '0;
        lfsr_tap = 1'b0;
        lfsr_reload = '0;
    endtask

    task automatic reg_write(logic [2:0] idx, logic [14:0] data);
        case (t_reg_idx'(idx))
            REG_VOL_LOW:   cfg.vol_low = data[3:0];
            REG_VOL_HIGH:  cfg.vol_high = data[3:0];
            REG_VOL_MODE:  cfg.vol_mode = data[3:0];
            REG_VOL_SPEED: cfg.vol_speed = data[7:0];
            REG_PER_LOW:   cfg.per_low = data;
            REG_PER_HIGH:  cfg.per_high = data;
            REG_PER_MODE:  cfg.per_mode = data[3:0];
            REG_PER_SPEED: cfg.per_speed = data[7:0];
            default: ;
        endcase
    endtask

    // one command beat into the voice; a tick queues the sample it makes
    task automatic voice_command(t_in_beat b);
        t_out_beat r;
        logic a;
        logic expired;
        case (t_cmd'(b.command))
            CMD_NOTE: begin
                bnd_vlow = cfg.vol_low;
                bnd_vhigh = cfg.vol_high;
                bnd_plow = cfg.per_low;
                bnd_phigh = cfg.per_high;
                vdir = cfg.vol_mode[3:2];
                pdir = cfg.per_mode[3:2];
                len_free = (b.note_length == 0);
                len_left = len_free ? 0 : int'(b.note_length) * LENGTH_UNIT;
                vol_count = 0;
                per_count = 0;
                half_per = (pdir == DIR_DOWN) ? cfg.per_high : cfg.per_low;
                level = (vdir == DIR_DOWN) ? cfg.vol_high : cfg.vol_low;
                lfsr = '0;
                lfsr_tap = 1'b0;
            end
            CMD_NOISE: begin
                lfsr = b.noise_seed;
                lfsr_tap = b.noise_tap_select;
                len_free = (b.note_length == 0);
                len_left = b.note_length;
                lfsr_reload = b.noise_period;
                countdown = {8'd0, b.noise_period};
                wave_silence();
            end
            CMD_QUIET: begin
                len_free = 1'b1;
                len_left = 0;
                level = '0;
                lfsr = '0;
                lfsr_tap = 1'b0;
            end
            default: begin
                if (lfsr == 0) begin
                    // tone mode
                    if (!len_free) begin
                        if (len_left == 0) level = '0;
                        else len_left--;
                    end
                    if (countdown > 0) begin
                        countdown--;
                    end else if (level == 0) begin
                        if (wave_out != 0) begin
                            retarget(0);
                            countdown = 16'd16;
                        end
                    end else begin
                        retarget(upper ? int'(level) : -int'(level));
                        countdown = {1'b0, half_per};
                        upper = !upper;
                        volume_step();
                        period_step();
                    end
                    wave_advance();
                    r.sample = wave_out;
                end else begin
                    // noise mode
                    expired = 1'b0;
                    if (!len_free) begin
                        if (len_left == 0) expired = 1'b1;
                        else len_left--;
                    end
                    if (expired) begin
                        lfsr = '0;
                        lfsr_tap = 1'b0;
                        r.sample = '0;
                    end else begin
                        if (countdown != 0) begin
                            countdown--;
                        end else begin
                            a = lfsr_tap ? lfsr[6] : lfsr[1];
                            countdown = {8'd0, lfsr_reload};
                            lfsr = {a ^ lfsr[0], lfsr[14:1]};
                        end
                        r.sample = {4'd0, lfsr[14:3]} - 16'd2048;
                    end
                end
                r.tone_silent = (wave_out == 0);
                samples_due.push_back(r);
            end
        endcase
    endtask

    // compare finished sample beats, then fold in new beats
    always @(posedge i_clk) begin
        t_out_beat want;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            voice_reset();
            samples_due.delete();
            o_fail_count <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (samples_due.size() == 0) begin
                    $display("%0t: sample beat with none expected: sample %0d silent %0b",
                             $time, i_out_data.sample, i_out_data.tone_silent);
                    errs++;
                end else begin
                    want = samples_due.pop_front();
                    if (i_out_data.sample !== want.sample) begin
                        $display("%0t: sample expected %0d actual %0d", $time,
                                 want.sample, i_out_data.sample);
                        errs++;
                    end
                    if (i_out_data.tone_silent !== want.tone_silent) begin
                        $display("%0t: tone_silent expected %0b actual %0b", $time,
                                 want.tone_silent, i_out_data.tone_silent);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
            if (i_cfg_we) reg_write(i_cfg_idx, i_cfg_data);
            if (i_in_valid && !i_in_stall) voice_command(i_in_data);
        end
        o_pending <= samples_due.size();
    end

endmodule

@@ dv/square_noise_sound_channel_top_tb.sv @@
// ----------------------------------------------------------------------------
// square_noise_sound_channel_top_tb
// drives command beats and register writes into the sound voice under random
// idling on both sides, across several register settings; the checker
// predicts and compares every sample beat
// ----------------------------------------------------------------------------
module square_noise_sound_channel_top_tb;
    import sqns_pkg::*;

    localparam int StuckLimit = 5000;
    localparam int PhaseBeats = 240;
    localparam int Phases = 6;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [14:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_beat    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_beat   o_out_data;

    int          fail_count;
    int          pending;
    int          stuck_cycles = 0;
    logic        calm = 1'b0;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    square_noise_sound_channel_top dut (.*);

    square_noise_sound_channel_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver stall
    always @(posedge i_clk) begin
        i_out_stall <= i_rst_n && !calm && ($urandom_range(99) < 33);
    end

    // watchdog on beats accepted
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= StuckLimit) begin
            $display("square_noise_sound_channel_top verification failed");
            $finish;
        end
    end

    // one command beat, with a random one-cycle gap in front
    task automatic send(t_in_beat b);
        if (!calm && $urandom_range(99) < 50) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_data <= b;
        i_in_valid <= 1'b1;
        forever begin
            @(negedge i_clk);
            if (!o_in_stall) break;
        end
        @(posedge i_clk);
    endtask

    task automatic send_cmd(t_cmd c, logic [15:0] len, logic [14:0] seed,
                            logic tap, logic [7:0] per);
        t_in_beat b;
        b.command = c;
        b.note_length = len;
        b.noise_seed = seed;
        b.noise_tap_select = tap;
        b.noise_period = per;
        send(b);
    endtask

    task automatic ticks(int n);
        repeat (n) send_cmd(CMD_TICK, 16'($urandom), 15'($urandom), 1'($urandom), 8'($urandom));
    endtask

    // stop sending and wait until every sample has come out
    task automatic drain();
        i_in_valid <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (pending == 0) break;
        end
        repeat (4) @(posedge i_clk);
    endtask

    // write a register; bits above its width carry noise
    task automatic reg_write(t_reg_idx idx, int unsigned value, int width);
        logic [14:0] data;
        data = 15'($urandom);
        data = (width >= 15) ? 15'(value) : ((data >> width) << width) | 15'(value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic program_phase(int phase);
        int unsigned v[8];
        case (phase)
            0: v = '{1, 8, 4, 0, 16, 20, 4, 0};
            1: v = '{15, 15, 15, 255, 32767, 32767, 15, 255};
            2: v = '{0, 0, 0, 0, 0, 0, 0, 0};
            3: v = '{1, 8, 9, 1, 16, 24000, 11, 1};
            default: begin
                v[0] = $urandom_range(15);
                v[1] = $urandom_range(15);
                v[2] = $urandom_range(15);
                v[3] = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(2);
                v[4] = $urandom_range(40);
                v[5] = $urandom_range(40);
                v[6] = $urandom_range(15);
                v[7] = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(3);
            end
        endcase
        reg_write(REG_VOL_LOW, v[0], 4);
        reg_write(REG_VOL_HIGH, v[1], 4);
        reg_write(REG_VOL_MODE, v[2], 4);
        reg_write(REG_VOL_SPEED, v[3], 8);
        reg_write(REG_PER_LOW, v[4], 15);
        reg_write(REG_PER_HIGH, v[5], 15);
        reg_write(REG_PER_MODE, v[6], 4);
        reg_write(REG_PER_SPEED, v[7], 8);
    endtask

    // random beat: mostly ticks, occasional note, noise and silence
    task automatic random_beat();
        int pick;
        logic [15:0] len;
        logic [14:0] seed;
        logic [7:0]  per;
        pick = $urandom_range(99);
        per = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7));
        seed = ($urandom_range(15) == 0) ? 15'd0 : 15'($urandom);
        if (pick < 84) begin
            ticks(1);
        end else if (pick < 91) begin
            len = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3));
            send_cmd(CMD_NOTE, len, seed, 1'($urandom), per);
        end else if (pick < 96) begin
            len = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(60));
            send_cmd(CMD_NOISE, len, seed, 1'($urandom), per);
        end else begin
            send_cmd(CMD_QUIET, 16'($urandom), 15'($urandom), 1'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: notes, noise extremes, zero seed, expiry, silence
        program_phase(0);
        send_cmd(CMD_NOTE, 16'd0, 15'd0, 1'b0, 8'd0);
        ticks(3);
        send_cmd(CMD_NOISE, 16'hFFFF, 15'h7FFF, 1'b1, 8'hFF);
        ticks(2);
        send_cmd(CMD_NOISE, 16'd2, 15'h0001, 1'b0, 8'd0);
        ticks(4);
        send_cmd(CMD_NOISE, 16'd3, 15'd0, 1'b0, 8'd0);
        ticks(4);
        send_cmd(CMD_NOTE, 16'd1, 15'd0, 1'b0, 8'd0);
        ticks(3);
        send_cmd(CMD_QUIET, 16'd0, 15'd0, 1'b0, 8'd0);
        ticks(2);
        drain();

        for (int phase = 0; phase < Phases; phase++) begin
            program_phase(phase);
            calm = (phase == 2);
            send_cmd(CMD_NOTE, 16'd0, 15'd0, 1'b0, 8'd0);
            for (int n = 0; n < PhaseBeats; n++) begin
                if (phase == 3 && n == PhaseBeats / 2) drain();
                random_beat();
            end
            drain();
        end
        calm = 1'b0;

        if (fail_count == 0 && pending == 0) begin
            $display("square_noise_sound_channel_top verification clean");
        end else begin
            $display("square_noise_sound_channel_top verification failed");
        end
        $finish;
    end

endmodule
